>>> hdl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared widths, codes and types for the closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Datapath widths
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int HALF_W    = DOT_W / 2;
  localparam int MID_W     = 2 * HALF_W + 2;
  localparam int AREA_W    = 2 * DOT_W;
  localparam int VOL_W     = AREA_W + 1;
  localparam int DIV_W     = VOL_W + 3;
  localparam int WGT_W     = 17;
  localparam int QUO_STEPS = WGT_W;

  // Pipeline depth: seven front stages, divider, output register
  localparam int FRONT_REGS = 7;
  localparam int DIV_REGS   = QUO_STEPS + 1;
  localparam int PIPE_LAT   = FRONT_REGS + DIV_REGS + 1;

  localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam logic [WGT_W-1:0] THIRD_Q16  = 17'd21845;
  localparam logic [WGT_W-1:0] THIRD_HI   = 17'd21846;

  typedef logic [2:0] region_t;
  typedef logic [1:0] div_mode_t;

  // Region codes
  localparam region_t REG_A      = 3'd0;
  localparam region_t REG_B      = 3'd1;
  localparam region_t REG_AB     = 3'd2;
  localparam region_t REG_C      = 3'd3;
  localparam region_t REG_AC     = 3'd4;
  localparam region_t REG_BC     = 3'd5;
  localparam region_t REG_INSIDE = 3'd6;
  localparam region_t REG_DEGEN  = 3'd7;

  // Divider lane modes
  localparam div_mode_t DIV_ZERO = 2'd0;
  localparam div_mode_t DIV_ONE  = 2'd1;
  localparam div_mode_t DIV_RUN  = 2'd2;

  // Partial products of one wide signed multiply
  typedef struct packed {
    logic signed [2*HALF_W-1:0] hh;
    logic signed [2*HALF_W:0]   hl;
    logic signed [2*HALF_W:0]   lh;
    logic [2*HALF_W-1:0]        ll;
  } part_t;

endpackage

>>> hdl/closest_point_on_triangle_top.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle_top
// Closest point of a triangle to a query point, as barycentric weights.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the three corners and the query point (signed Q8.16) on the in_
//   ports and raise start. A transaction is taken at each edge with start high
//   and busy low. Busy stays low, so a new query can enter every cycle.
//   Each result shows on the out_ ports for one cycle with out_valid high.
//   Results come out in query order.
//   The pipeline has seven front stages (differences, dot products, wide
//   area products in partial products, region select), 18 divider stages
//   (operand capture, then one quotient bit per stage) and the output
//   register.
//   Throughput: one query per cycle.
//   The receiver cannot stall; results are not held.
//   Reset clears all valid bits; queries in flight are dropped.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_a_x,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_a_y,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_a_z,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_b_x,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_b_y,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_b_z,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_c_x,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_c_y,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_vertex_c_z,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_query_x,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_query_y,
  input  logic signed [cpt_pkg::COORD_W-1:0] in_query_z,
  output logic                               out_valid,
  output logic [cpt_pkg::WGT_W-1:0]          out_weight_a,
  output logic [cpt_pkg::WGT_W-1:0]          out_weight_b,
  output logic [cpt_pkg::WGT_W-1:0]          out_weight_c,
  output cpt_pkg::region_t                   out_region
);
  import cpt_pkg::*;

  function automatic part_t mul_parts(input logic signed [DOT_W-1:0] x,
                                      input logic signed [DOT_W-1:0] y);
    logic signed [HALF_W-1:0] xh;
    logic signed [HALF_W-1:0] yh;
    logic [HALF_W-1:0]        xl;
    logic [HALF_W-1:0]        yl;
    part_t                    p;
    xh   = x[DOT_W-1:HALF_W];
    yh   = y[DOT_W-1:HALF_W];
    xl   = x[HALF_W-1:0];
    yl   = y[HALF_W-1:0];
    p.hh = xh * yh;
    p.hl = xh * $signed({1'b0, yl});
    p.lh = $signed({1'b0, xl}) * yh;
    p.ll = xl * yl;
    return p;
  endfunction

  function automatic logic signed [AREA_W-1:0] part_sum(input part_t p);
    logic signed [MID_W-1:0] mid;
    logic [AREA_W-1:0]       s;
    mid = MID_W'($signed(p.hl)) + MID_W'($signed(p.lh));
    s   = {p.hh, {(2*HALF_W){1'b0}}}
        + {{(AREA_W-MID_W-HALF_W){mid[MID_W-1]}}, mid, {HALF_W{1'b0}}}
        + {{(AREA_W-2*HALF_W){1'b0}}, p.ll};
    return $signed(s);
  endfunction

  function automatic div_mode_t lane_mode(input logic signed [DIV_W-1:0] n,
                                          input logic signed [DIV_W-1:0] d);
    if (d <= 0 || n < 0) return DIV_ZERO;
    else if (n >= d)     return DIV_ONE;
    else                 return DIV_RUN;
  endfunction

  logic                     accept;
  logic [PIPE_LAT-1:0]      vld_r, vld_nxt;
  logic signed [COORD_W-1:0] pa [3], pb [3], pc [3], pq [3];

  logic signed [DIFF_W-1:0] ab_r [3], ac_r [3], ap_r [3], bp_r [3], cp_r [3];
  logic signed [DIFF_W-1:0] ab_nxt [3], ac_nxt [3], ap_nxt [3], bp_nxt [3], cp_nxt [3];
  logic signed [PROD_W-1:0] pr_r [6][3], pr_nxt [6][3];
  logic signed [DOT_W-1:0]  d3_r [6], d3_nxt [6];
  logic signed [DOT_W-1:0]  d4_r [6], d5_r [6], d6_r [6];
  part_t                    pt_r [6], pt_nxt [6];
  logic signed [AREA_W-1:0] ar_r [6], ar_nxt [6];
  logic signed [VOL_W-1:0]  va_r, vb_r, vc_r, va_nxt, vb_nxt, vc_nxt;

  region_t                  reg_r, reg_nxt;
  logic signed [DIV_W-1:0]  na_r, da_r, nb_r, db_r, na_nxt, da_nxt, nb_nxt, db_nxt;
  region_t                  rg_r [DIV_REGS], rg_nxt [DIV_REGS];
  logic [WGT_W-1:0]         qa, qb;
  logic [WGT_W-1:0]         wa_r, wb_r, wc_r, wa_nxt, wb_nxt, wc_nxt;
  region_t                  ro_r, ro_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign pa = '{in_vertex_a_x, in_vertex_a_y, in_vertex_a_z};
  assign pb = '{in_vertex_b_x, in_vertex_b_y, in_vertex_b_z};
  assign pc = '{in_vertex_c_x, in_vertex_c_y, in_vertex_c_z};
  assign pq = '{in_query_x, in_query_y, in_query_z};

  // Advance valid bits with the data
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: edge and offset vectors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab_nxt[i] = DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
      ac_nxt[i] = DIFF_W'(pc[i]) - DIFF_W'(pa[i]);
      ap_nxt[i] = DIFF_W'(pq[i]) - DIFF_W'(pa[i]);
      bp_nxt[i] = DIFF_W'(pq[i]) - DIFF_W'(pb[i]);
      cp_nxt[i] = DIFF_W'(pq[i]) - DIFF_W'(pc[i]);
    end
  end

  // Stage 2: component products of the six dot products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_nxt[0][i] = ab_r[i] * ap_r[i];
      pr_nxt[1][i] = ac_r[i] * ap_r[i];
      pr_nxt[2][i] = ab_r[i] * bp_r[i];
      pr_nxt[3][i] = ac_r[i] * bp_r[i];
      pr_nxt[4][i] = ab_r[i] * cp_r[i];
      pr_nxt[5][i] = ac_r[i] * cp_r[i];
    end
  end

  // Stage 3: sum into d1..d6
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      d3_nxt[k] = DOT_W'(pr_r[k][0]) + DOT_W'(pr_r[k][1]) + DOT_W'(pr_r[k][2]);
    end
  end

  // Stage 4: partial products of the area terms
  always_comb begin
    pt_nxt[0] = mul_parts(d3_r[0], d3_r[3]);
    pt_nxt[1] = mul_parts(d3_r[2], d3_r[1]);
    pt_nxt[2] = mul_parts(d3_r[4], d3_r[1]);
    pt_nxt[3] = mul_parts(d3_r[0], d3_r[5]);
    pt_nxt[4] = mul_parts(d3_r[2], d3_r[5]);
    pt_nxt[5] = mul_parts(d3_r[4], d3_r[3]);
  end

  // Stage 5: recombine the partial products
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ar_nxt[k] = part_sum(pt_r[k]);
    end
  end

  // Stage 6: area terms
  assign vc_nxt = VOL_W'(ar_r[0]) - VOL_W'(ar_r[1]);
  assign vb_nxt = VOL_W'(ar_r[2]) - VOL_W'(ar_r[3]);
  assign va_nxt = VOL_W'(ar_r[4]) - VOL_W'(ar_r[5]);

  // Stage 7: pick the region and the divider operands
  always_comb begin
    logic signed [DOT_W:0]   e43;
    logic signed [DOT_W:0]   e56;
    logic signed [DIV_W-1:0] den_in;
    e43    = (DOT_W+1)'(d6_r[3]) - (DOT_W+1)'(d6_r[2]);
    e56    = (DOT_W+1)'(d6_r[4]) - (DOT_W+1)'(d6_r[5]);
    den_in = DIV_W'(va_r) + DIV_W'(vb_r) + DIV_W'(vc_r);
    na_nxt = '0;
    da_nxt = '0;
    nb_nxt = '0;
    db_nxt = '0;
    if (d6_r[0] <= 0 && d6_r[1] <= 0) begin
      reg_nxt = REG_A;
    end else if (d6_r[2] >= 0 && d6_r[3] <= d6_r[2]) begin
      reg_nxt = REG_B;
    end else if (vc_r <= 0 && d6_r[0] >= 0 && d6_r[2] <= 0) begin
      reg_nxt = REG_AB;
      na_nxt  = DIV_W'(d6_r[0]);
      da_nxt  = DIV_W'(d6_r[0]) - DIV_W'(d6_r[2]);
    end else if (d6_r[5] >= 0 && d6_r[4] <= d6_r[5]) begin
      reg_nxt = REG_C;
    end else if (vb_r <= 0 && d6_r[1] >= 0 && d6_r[5] <= 0) begin
      reg_nxt = REG_AC;
      na_nxt  = DIV_W'(d6_r[1]);
      da_nxt  = DIV_W'(d6_r[1]) - DIV_W'(d6_r[5]);
    end else if (va_r <= 0 && e43 >= 0 && e56 >= 0) begin
      reg_nxt = REG_BC;
      na_nxt  = DIV_W'(e43);
      da_nxt  = DIV_W'(e43) + DIV_W'(e56);
    end else if (den_in <= 0) begin
      reg_nxt = REG_DEGEN;
    end else begin
      reg_nxt = REG_INSIDE;
      na_nxt  = DIV_W'(vb_r);
      da_nxt  = den_in;
      nb_nxt  = DIV_W'(vc_r);
      db_nxt  = den_in;
    end
  end

  always_ff @(posedge clk) begin
    ab_r  <= ab_nxt;
    ac_r  <= ac_nxt;
    ap_r  <= ap_nxt;
    bp_r  <= bp_nxt;
    cp_r  <= cp_nxt;
    pr_r  <= pr_nxt;
    d3_r  <= d3_nxt;
    d4_r  <= d3_r;
    pt_r  <= pt_nxt;
    d5_r  <= d4_r;
    ar_r  <= ar_nxt;
    d6_r  <= d5_r;
    va_r  <= va_nxt;
    vb_r  <= vb_nxt;
    vc_r  <= vc_nxt;
    reg_r <= reg_nxt;
    na_r  <= na_nxt;
    da_r  <= da_nxt;
    nb_r  <= nb_nxt;
    db_r  <= db_nxt;
  end

  // Two divider lanes: edge or first interior weight, second interior weight
  cpt_div u_div_a (
    .clk  (clk),
    .num  (na_r),
    .den  (da_r),
    .mode (lane_mode(na_r, da_r)),
    .quo  (qa)
  );

  cpt_div u_div_b (
    .clk  (clk),
    .num  (nb_r),
    .den  (db_r),
    .mode (lane_mode(nb_r, db_r)),
    .quo  (qb)
  );

  // Carry the region code alongside the divider
  always_comb begin
    rg_nxt[0] = reg_r;
    for (int k = 1; k < DIV_REGS; k++) begin
      rg_nxt[k] = rg_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    rg_r <= rg_nxt;
  end

  // Output stage: form the three weights
  always_comb begin
    logic [WGT_W:0]   vw;
    logic [WGT_W-1:0] wi;
    vw     = {1'b0, qa} + {1'b0, qb};
    wi     = (vw > {1'b0, WEIGHT_ONE}) ? WEIGHT_ONE - qa : qb;
    ro_nxt = rg_r[DIV_REGS-1];
    case (rg_r[DIV_REGS-1])
      REG_A: begin
        wa_nxt = WEIGHT_ONE; wb_nxt = '0; wc_nxt = '0;
      end
      REG_B: begin
        wa_nxt = '0; wb_nxt = WEIGHT_ONE; wc_nxt = '0;
      end
      REG_C: begin
        wa_nxt = '0; wb_nxt = '0; wc_nxt = WEIGHT_ONE;
      end
      REG_AB: begin
        wa_nxt = WEIGHT_ONE - qa; wb_nxt = qa; wc_nxt = '0;
      end
      REG_AC: begin
        wa_nxt = WEIGHT_ONE - qa; wb_nxt = '0; wc_nxt = qa;
      end
      REG_BC: begin
        wa_nxt = '0; wb_nxt = WEIGHT_ONE - qa; wc_nxt = qa;
      end
      REG_INSIDE: begin
        wa_nxt = WEIGHT_ONE - qa - wi; wb_nxt = qa; wc_nxt = wi;
      end
      default: begin
        wa_nxt = THIRD_HI; wb_nxt = THIRD_Q16; wc_nxt = THIRD_Q16;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    wa_r <= wa_nxt;
    wb_r <= wb_nxt;
    wc_r <= wc_nxt;
    ro_r <= ro_nxt;
  end

  assign out_valid    = vld_r[PIPE_LAT-1];
  assign out_weight_a = wa_r;
  assign out_weight_b = wb_r;
  assign out_weight_c = wc_r;
  assign out_region   = ro_r;

endmodule

>>> hdl/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider: one quotient bit per stage, Q1.16 rounded.
// ----------------------------------------------------------------------------
module cpt_div (
  input  logic                        clk,
  input  logic [cpt_pkg::DIV_W-1:0]   num,
  input  logic [cpt_pkg::DIV_W-1:0]   den,
  input  cpt_pkg::div_mode_t          mode,
  output logic [cpt_pkg::WGT_W-1:0]   quo
);
  import cpt_pkg::*;

  logic [DIV_W-1:0]     rem_r [DIV_REGS];
  logic [DIV_W-1:0]     rem_nxt [DIV_REGS];
  logic [DIV_W-1:0]     den_r [DIV_REGS];
  logic [DIV_W-1:0]     den_nxt [DIV_REGS];
  logic [QUO_STEPS-1:0] q_r [DIV_REGS];
  logic [QUO_STEPS-1:0] q_nxt [DIV_REGS];
  div_mode_t            mode_r [DIV_REGS];
  div_mode_t            mode_nxt [DIV_REGS];
  logic [WGT_W:0]       rnd;

  // Capture operands, then one shift-compare-subtract per stage
  always_comb begin
    logic [DIV_W:0] sh;
    logic [DIV_W:0] dif;
    rem_nxt[0]  = num;
    den_nxt[0]  = den;
    q_nxt[0]    = '0;
    mode_nxt[0] = mode;
    for (int k = 1; k < DIV_REGS; k++) begin
      sh  = {rem_r[k-1], 1'b0};
      dif = sh - {1'b0, den_r[k-1]};
      den_nxt[k]  = den_r[k-1];
      mode_nxt[k] = mode_r[k-1];
      if (sh >= {1'b0, den_r[k-1]}) begin
        rem_nxt[k] = dif[DIV_W-1:0];
        q_nxt[k]   = {q_r[k-1][QUO_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[DIV_W-1:0];
        q_nxt[k]   = {q_r[k-1][QUO_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    mode_r <= mode_nxt;
  end

  // Round half up and apply the forced results
  assign rnd = {1'b0, q_r[DIV_REGS-1]} + (WGT_W+1)'(1);

  always_comb begin
    case (mode_r[DIV_REGS-1])
      DIV_ZERO: quo = '0;
      DIV_ONE:  quo = WEIGHT_ONE;
      default:  quo = rnd[WGT_W:1];
    endcase
  end

endmodule

>>> hdl/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cpt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      busy,
  input logic                      out_valid,
  input logic [cpt_pkg::WGT_W-1:0] out_weight_a,
  input logic [cpt_pkg::WGT_W-1:0] out_weight_b,
  input logic [cpt_pkg::WGT_W-1:0] out_weight_c,
  input cpt_pkg::region_t          out_region
);
  import cpt_pkg::*;

  logic [WGT_W+1:0] wsum;

  assign wsum = (WGT_W+2)'(out_weight_a) + (WGT_W+2)'(out_weight_b)
              + (WGT_W+2)'(out_weight_c);

  // Weights of every transaction sum to one
  a_sum_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> wsum == (WGT_W+2)'(WEIGHT_ONE))
    else $error("weights do not sum to one");

  // Vertex region A puts the full weight on corner A
  a_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == REG_A |-> out_weight_a == WEIGHT_ONE)
    else $error("vertex A weight wrong");

  // A degenerate triangle reports the centroid
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == REG_DEGEN |->
      out_weight_b == THIRD_Q16 && out_weight_c == THIRD_Q16)
    else $error("degenerate weights wrong");

  // Busy, which would hold off a query, stays low after each valid result
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid) |-> !busy)
    else $error("busy raised");

endmodule

bind closest_point_on_triangle_top cpt_checker u_cpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_weight_a (out_weight_a),
  .out_weight_b (out_weight_b),
  .out_weight_c (out_weight_c),
  .out_region   (out_region)
);
